// ----- design/fsp_pkg.sv -----
// Package for the frame sequence player: sizes, command and register codes,
// and the word types of the input, result and configuration paths.
// No dependencies.
package fsp_pkg;

    localparam int MAX_STEPS = 16;
    localparam int TIME_BITS = 16;
    localparam int STEP_W    = $clog2(MAX_STEPS);
    localparam int CNT_W     = STEP_W + 1;
    localparam int ELAPSED_W = TIME_BITS + 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 8;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_PLAY   = 2'd1,
        CMD_STOP   = 2'd2,
        CMD_WR_DUR = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEP_COUNT = 3'd0,
        REG_ALT_MODE   = 3'd1,
        REG_ITER_LIMIT = 3'd2,
        REG_AUTO_ADV   = 3'd3,
        REG_IDLE_FRAME = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        t_cmd                 cmd;
        logic [TIME_BITS-1:0] tick_amount;
        logic [3:0]           step_index;
        logic [TIME_BITS-1:0] duration;
    } t_in_item;

    typedef struct packed {
        logic [3:0] frame_index;
        logic       frame_valid;
        logic       is_playing;
        logic       step_changed;
        logic       iteration_done;
        logic       finished;
    } t_out_item;

    // register values plus a pulse that reloads the remaining run count
    typedef struct packed {
        logic [4:0]        step_count;
        logic              alternate_mode;
        logic [7:0]        iteration_limit;
        logic              auto_advance;
        logic signed [4:0] idle_frame;
        logic              limit_load;
    } t_cfg;

endpackage

// ----- design/fsp_cfg_regs.sv -----
// Configuration registers of the frame sequence player.
// Depends on fsp_pkg.
module fsp_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [fsp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [fsp_pkg::CFG_DAT_W-1:0] i_cfg_data,
    output fsp_pkg::t_cfg                 o_cfg
);
    import fsp_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        n_cfg.limit_load = 1'b0;
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                REG_STEP_COUNT: n_cfg.step_count = i_cfg_data[4:0];
                REG_ALT_MODE:   n_cfg.alternate_mode = i_cfg_data[0];
                REG_ITER_LIMIT: begin
                    n_cfg.iteration_limit = i_cfg_data[7:0];
                    n_cfg.limit_load = 1'b1;
                end
                REG_AUTO_ADV:   n_cfg.auto_advance = i_cfg_data[0];
                REG_IDLE_FRAME: n_cfg.idle_frame = $signed(i_cfg_data[4:0]);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_count      <= 5'd1;
            r_cfg.alternate_mode  <= 1'b0;
            r_cfg.iteration_limit <= 8'd1;
            r_cfg.auto_advance    <= 1'b1;
            r_cfg.idle_frame      <= -5'sd1;
            r_cfg.limit_load      <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- design/fsp_seq.sv -----
// Sequencer state of the frame sequence player: step durations, elapsed
// time, step position, direction and run count; computes one result word.
// Depends on fsp_pkg.
module fsp_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  fsp_pkg::t_in_item  i_item,
    input  fsp_pkg::t_cfg      i_cfg,
    output fsp_pkg::t_out_item o_result
);
    import fsp_pkg::*;

    logic [TIME_BITS-1:0] r_dur [MAX_STEPS];
    logic [ELAPSED_W-1:0] r_elapsed, n_elapsed;
    logic [STEP_W-1:0]    r_step, n_step;
    logic                 r_back, n_back;
    logic                 r_was_back, n_was_back;
    logic [7:0]           r_left, n_left;
    logic                 r_playing, n_playing;

    logic [CNT_W-1:0]     live_n;
    logic [STEP_W-1:0]    last;
    logic [ELAPSED_W:0]   sum;
    logic [ELAPSED_W-1:0] sat;
    logic                 reach;
    logic [STEP_W-1:0]    next_step;
    logic                 iter;
    logic [7:0]           left_now;
    logic [7:0]           left_dec;
    logic                 chg, fin;

    always_comb begin
        if (i_cfg.step_count == 5'd0) begin
            live_n = CNT_W'(1);
        end else if (int'(i_cfg.step_count) > MAX_STEPS) begin
            live_n = CNT_W'(MAX_STEPS);
        end else begin
            live_n = CNT_W'(i_cfg.step_count);
        end
        last = STEP_W'(live_n - CNT_W'(1));
    end

    assign sum   = {1'b0, r_elapsed} + (ELAPSED_W+1)'(i_item.tick_amount);
    assign sat   = sum[ELAPSED_W] ? {ELAPSED_W{1'b1}} : sum[ELAPSED_W-1:0];
    assign reach = sat >= ELAPSED_W'(r_dur[r_step]);

    // a limit write reloads the run count, seen here while the load is pending
    assign left_now = i_cfg.limit_load ? i_cfg.iteration_limit : r_left;

    always_comb begin
        if (!r_back) begin
            next_step = (CNT_W'(r_step) + CNT_W'(1) >= live_n) ? '0 : r_step + STEP_W'(1);
        end else if (r_step == '0 || CNT_W'(r_step) - CNT_W'(1) >= live_n) begin
            next_step = last;
        end else begin
            next_step = r_step - STEP_W'(1);
        end
    end

    always_comb begin
        n_elapsed  = r_elapsed;
        n_step     = r_step;
        n_back     = r_back;
        n_was_back = r_was_back;
        n_left     = left_now;
        n_playing  = r_playing;
        chg        = 1'b0;
        iter       = 1'b0;
        fin        = 1'b0;
        left_dec   = (left_now != 8'd0) ? left_now - 8'd1 : 8'd0;
        unique case (i_item.cmd)
            CMD_TICK: begin
                if (r_playing) begin
                    if (!i_cfg.auto_advance) n_playing = 1'b0;
                    if (reach) begin
                        n_step    = next_step;
                        n_elapsed = '0;
                        chg       = 1'b1;
                    end else begin
                        n_elapsed = sat;
                    end
                    if (!i_cfg.alternate_mode) begin
                        iter = reach && (r_step == last);
                    end else begin
                        iter = reach && (r_step == '0) && r_was_back;
                        // direction flips at either end of the ping-pong
                        if (reach && next_step == last && !r_back) begin
                            n_was_back = 1'b0;
                            n_back     = 1'b1;
                        end else if (reach && next_step == '0 && r_back) begin
                            n_was_back = 1'b1;
                            n_back     = 1'b0;
                        end
                    end
                    if (iter && i_cfg.iteration_limit != 8'd0) begin
                        n_left = left_dec;
                        if (left_dec == 8'd0) begin
                            n_playing  = 1'b0;
                            n_elapsed  = '0;
                            n_step     = '0;
                            n_back     = 1'b0;
                            n_was_back = 1'b0;
                            n_left     = i_cfg.iteration_limit;
                            fin        = 1'b1;
                        end
                    end
                end
            end
            CMD_PLAY: n_playing = 1'b1;
            CMD_STOP: begin
                n_playing  = 1'b0;
                n_elapsed  = '0;
                n_step     = '0;
                n_back     = 1'b0;
                n_was_back = 1'b0;
            end
            CMD_WR_DUR: ;
            default: ;
        endcase
    end

    always_comb begin
        o_result = '0;
        o_result.is_playing     = n_playing;
        o_result.step_changed   = chg;
        o_result.iteration_done = iter;
        o_result.finished       = fin;
        if (n_playing) begin
            o_result.frame_valid = 1'b1;
            o_result.frame_index = 4'(n_step);
        end else if (!i_cfg.idle_frame[4]) begin
            o_result.frame_valid = 1'b1;
            o_result.frame_index = i_cfg.idle_frame[3:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && i_item.cmd == CMD_WR_DUR && int'(i_item.step_index) < MAX_STEPS) begin
            r_dur[STEP_W'(i_item.step_index)] <= i_item.duration;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed  <= '0;
            r_step     <= '0;
            r_back     <= 1'b0;
            r_was_back <= 1'b0;
            r_left     <= 8'd1;
            r_playing  <= 1'b0;
        end else begin
            if (i_fire) begin
                r_elapsed  <= n_elapsed;
                r_step     <= n_step;
                r_back     <= n_back;
                r_was_back <= n_was_back;
                r_left     <= n_left;
                r_playing  <= n_playing;
            end else if (i_cfg.limit_load) begin
                r_left <= i_cfg.iteration_limit;
            end
        end
    end

endmodule

// ----- design/frame_sequence_player_core.sv -----
// Frame sequence player. One command word per item (tick, play, stop, write
// duration) yields one result word. Throughput is one word per clock while
// the result side does not stall: an accepted word is held in the input
// register while the sequencer works it out in a single combinational pass,
// and the result register then takes it. A stalled result register holds
// the input register, which stalls the input.
module frame_sequence_player_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  fsp_pkg::t_in_item             i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output fsp_pkg::t_out_item            o_out_item,
    input  logic                          i_cfg_we,
    input  logic [fsp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [fsp_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import fsp_pkg::*;

    t_in_item  r_in;
    logic      r_in_valid;
    t_out_item r_out;
    logic      r_out_valid;
    t_out_item result;
    t_cfg      cfg;
    logic      fire;

    assign fire       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !fire;

    fsp_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    fsp_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) r_in <= i_in_item;
        if (fire) r_out <= result;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ----- design/fsp_checker.sv -----
// Port-level checks for the frame sequence player, bound to the top level.
// Depends on fsp_pkg.
module fsp_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input fsp_pkg::t_in_item             i_in_item,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input fsp_pkg::t_out_item            o_out_item,
    input logic                          i_cfg_we,
    input logic [fsp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input logic [fsp_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import fsp_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result word changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_finish_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.finished |-> o_out_item.iteration_done
            && !o_out_item.is_playing)
        else $error("finish without iteration end or still playing");

    a_iter_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.iteration_done |-> o_out_item.step_changed)
        else $error("iteration done without a step change");

    a_no_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.frame_valid |-> o_out_item.frame_index == 4'd0
            && !o_out_item.is_playing)
        else $error("blank frame with index or while playing");

endmodule

bind frame_sequence_player_core fsp_checker u_fsp_checker (.*);

// ----- dv/frame_sequence_player_checker.sv -----
// Scoreboard for the frame sequence player: watches the config port and both
// word channels, predicts each result word and compares it field by field.
// Depends on fsp_pkg.
module frame_sequence_player_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  fsp_pkg::t_in_item             i_in_item,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  fsp_pkg::t_out_item            i_out_item,
    input  logic                          i_cfg_we,
    input  logic [fsp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [fsp_pkg::CFG_DAT_W-1:0] i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import fsp_pkg::*;

    localparam logic [ELAPSED_W-1:0] ELAPSED_SAT = '1;

    // register copies
    logic [4:0]        steps_cfg;
    logic              alt_mode;
    logic [7:0]        iter_limit;
    logic              auto_adv;
    logic signed [4:0] idle_frm;

    // sequencer state
    logic [TIME_BITS-1:0] dur_tbl [MAX_STEPS];
    logic [ELAPSED_W-1:0] elapsed;
    logic [STEP_W-1:0]    cur_step;
    logic                 back;
    logic                 was_back;
    logic [7:0]           iters_left;
    logic                 playing;

    t_out_item frame_q [$];
    int        fails = 0;

    function automatic void clear_run();
        playing  = 1'b0;
        elapsed  = '0;
        cur_step = '0;
        back     = 1'b0;
        was_back = 1'b0;
    endfunction

    function automatic t_out_item play_word(t_in_item w);
        t_out_item            r;
        int                   n;
        int                   last_pos;
        int                   pos;
        logic [ELAPSED_W:0]   sum;
        logic                 hit_last;
        logic                 hit_first;
        logic                 changed;
        logic                 iter;
        r = '0;
        changed = 1'b0;
        iter = 1'b0;
        case (w.cmd)
            CMD_TICK: begin
                if (playing) begin
                    n = (steps_cfg == 0) ? 1 :
                        (int'(steps_cfg) > MAX_STEPS) ? MAX_STEPS : int'(steps_cfg);
                    last_pos = n - 1;
                    if (!auto_adv) playing = 1'b0;
                    pos = int'(cur_step);
                    hit_first = (pos == 0);
                    hit_last = (pos == last_pos);
                    sum = {1'b0, elapsed} + (ELAPSED_W+1)'(w.tick_amount);
                    elapsed = sum[ELAPSED_W] ? ELAPSED_SAT : sum[ELAPSED_W-1:0];
                    if (elapsed >= ELAPSED_W'(dur_tbl[cur_step])) begin
                        if (!back) begin
                            pos = (pos + 1 >= n) ? 0 : pos + 1;
                        end else if (pos == 0 || pos - 1 >= n) begin
                            pos = last_pos;
                        end else begin
                            pos = pos - 1;
                        end
                        cur_step = STEP_W'(pos);
                        elapsed = '0;
                        changed = 1'b1;
                    end
                    if (!alt_mode) begin
                        iter = hit_last && changed;
                    end else begin
                        // a ping-pong pass ends when step zero is left after the return to it
                        iter = hit_first && changed && was_back;
                        if (changed && pos == last_pos && !back) begin
                            was_back = 1'b0;
                            back = 1'b1;
                        end else if (changed && pos == 0 && back) begin
                            was_back = 1'b1;
                            back = 1'b0;
                        end
                    end
                    r.step_changed = changed;
                    r.iteration_done = iter;
                    if (iter && iter_limit != 0) begin
                        if (iters_left != 0) iters_left = iters_left - 1;
                        if (iters_left == 0) begin
                            clear_run();
                            iters_left = iter_limit;
                            r.finished = 1'b1;
                        end
                    end
                end
            end
            CMD_PLAY: playing = 1'b1;
            CMD_STOP: clear_run();
            default: dur_tbl[w.step_index] = w.duration;
        endcase
        if (playing) begin
            r.frame_valid = 1'b1;
            r.frame_index = cur_step[3:0];
        end else if (!idle_frm[4]) begin
            r.frame_valid = 1'b1;
            r.frame_index = idle_frm[3:0];
        end
        r.is_playing = playing;
        return r;
    endfunction

    function automatic void check_field(string name, logic [3:0] exp_v, logic [3:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            steps_cfg  = 5'd1;
            alt_mode   = 1'b0;
            iter_limit = 8'd1;
            auto_adv   = 1'b1;
            idle_frm   = -5'sd1;
            iters_left = 8'd1;
            clear_run();
            frame_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_STEP_COUNT: steps_cfg = i_cfg_data[4:0];
                    REG_ALT_MODE:   alt_mode = i_cfg_data[0];
                    REG_ITER_LIMIT: begin
                        iter_limit = i_cfg_data;
                        iters_left = i_cfg_data;
                    end
                    REG_AUTO_ADV:   auto_adv = i_cfg_data[0];
                    REG_IDLE_FRAME: idle_frm = i_cfg_data[4:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) frame_q.push_back(play_word(i_in_item));
            if (i_out_valid && !i_out_stall) begin
                if (frame_q.size() == 0) begin
                    $error("result word %h arrived with nothing expected", i_out_item);
                    fails++;
                end else begin
                    want = frame_q.pop_front();
                    check_field("frame_index", want.frame_index, i_out_item.frame_index);
                    check_field("frame_valid", want.frame_valid, i_out_item.frame_valid);
                    check_field("is_playing", want.is_playing, i_out_item.is_playing);
                    check_field("step_changed", want.step_changed, i_out_item.step_changed);
                    check_field("iteration_done", want.iteration_done,
                                i_out_item.iteration_done);
                    check_field("finished", want.finished, i_out_item.finished);
                end
            end
        end
        o_fail_count <= fails;
        o_pending <= frame_q.size();
    end

endmodule

// ----- dv/tb_frame_sequence_player_core.sv -----
// Testbench top for frame_sequence_player_core: clock, reset, config writes
// and command words with random idling; checking is done in the checker.
// Depends on fsp_pkg, frame_sequence_player_core, frame_sequence_player_checker.
module tb_frame_sequence_player_core;
    timeunit 1ns;
    timeprecision 1ps;
    import fsp_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int NUM_PHASES     = 14;
    localparam logic [4:0] ALL_REGS = 5'h1F;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    t_in_item             in_word   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_out_item            out_word;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx   = '0;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;

    int fail_count;
    int pending;
    int gap_pct      = 0;
    int quiet_cycles = 0;

    frame_sequence_player_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    frame_sequence_player_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_word),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_word),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 clk = ~clk;

    // result side back-pressure in bursts
    initial begin
        forever begin
            @(negedge clk);
            if ($urandom_range(0, 99) < gap_pct) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic t_in_item mk_word(t_cmd cmd, logic [TIME_BITS-1:0] amount,
                                         logic [3:0] idx, logic [TIME_BITS-1:0] dur);
        t_in_item w;
        w.cmd = cmd;
        w.tick_amount = amount;
        w.step_index = idx;
        w.duration = dur;
        return w;
    endfunction

    // mostly play and short ticks so runs step, wrap and finish often
    function automatic t_in_item rand_word();
        t_in_item w;
        int       pick;
        pick = $urandom_range(0, 99);
        w.cmd = (pick < 60) ? CMD_TICK : (pick < 80) ? CMD_PLAY :
                (pick < 85) ? CMD_STOP : CMD_WR_DUR;
        pick = $urandom_range(0, 9);
        w.tick_amount = (pick < 7) ? TIME_BITS'($urandom_range(0, 12)) :
                        (pick < 9) ? TIME_BITS'($urandom_range(0, 65535)) :
                        ($urandom_range(0, 1) ? '1 : '0);
        w.step_index = 4'($urandom_range(0, 15));
        pick = $urandom_range(0, 9);
        w.duration = (pick < 6) ? TIME_BITS'($urandom_range(0, 10)) :
                     (pick < 8) ? TIME_BITS'($urandom_range(0, 400)) :
                     (pick < 9) ? TIME_BITS'($urandom_range(0, 65535)) : '1;
        return w;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_word(t_in_item w);
        if ($urandom_range(0, 99) < gap_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    // config only goes in with the pipe empty
    task automatic apply_config(logic [4:0] which, logic [4:0] steps, logic alt,
                                logic [7:0] limit, logic auto_on, logic [4:0] idle);
        logic [CFG_DAT_W-1:0] vals [5];
        vals[REG_STEP_COUNT] = CFG_DAT_W'(steps);
        vals[REG_ALT_MODE]   = CFG_DAT_W'(alt);
        vals[REG_ITER_LIMIT] = limit;
        vals[REG_AUTO_ADV]   = CFG_DAT_W'(auto_on);
        vals[REG_IDLE_FRAME] = CFG_DAT_W'(idle);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        for (int i = 0; i <= int'(REG_IDLE_FRAME); i++) begin
            if (which[i]) begin
                cfg_we <= 1'b1;
                cfg_idx <= CFG_IDX_W'(i);
                cfg_data <= vals[i];
                @(negedge clk);
            end
        end
        cfg_we <= 1'b0;
    endtask

    initial begin
        int         n_words;
        int         pick;
        logic [4:0] steps;
        logic [7:0] limit;

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: idle tick, fill all durations, finish on a one-step run,
        // stops, then extreme settings with manual advance
        send_word(mk_word(CMD_TICK, '1, 4'd0, '0));
        for (int i = 0; i < MAX_STEPS; i++) begin
            send_word(mk_word(CMD_WR_DUR, TIME_BITS'($urandom), 4'(i),
                              (i == 0) ? '0 : (i == MAX_STEPS - 1) ? '1 :
                              TIME_BITS'($urandom_range(1, 8))));
        end
        send_word(mk_word(CMD_PLAY, '0, 4'd0, '0));
        send_word(mk_word(CMD_TICK, '0, 4'd0, '0));
        send_word(mk_word(CMD_PLAY, '0, 4'd0, '0));
        send_word(mk_word(CMD_STOP, '0, 4'd0, '0));
        send_word(mk_word(CMD_STOP, '1, 4'd15, '1));
        apply_config(ALL_REGS, 5'd31, 1'b1, 8'd0, 1'b0, 5'd15);
        send_word(mk_word(CMD_PLAY, '0, 4'd0, '0));
        send_word(mk_word(CMD_TICK, '1, 4'd0, '0));
        send_word(mk_word(CMD_TICK, 16'd3, 4'd0, '0));
        apply_config(5'(1 << REG_IDLE_FRAME), 5'd0, 1'b0, 8'd0, 1'b0, 5'h10);
        send_word(mk_word(CMD_TICK, 16'd1, 4'd0, '0));

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            pick = $urandom_range(0, 9);
            steps = (ph == 0) ? 5'd16 : (ph == 1) ? 5'd0 : (ph == 2) ? 5'd31 :
                    (pick < 3) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(1, 6));
            pick = $urandom_range(0, 19);
            limit = (ph == 0) ? 8'd255 : (ph == 1) ? 8'd0 :
                    (pick < 2) ? 8'd0 : (pick < 3) ? 8'd255 : 8'($urandom_range(1, 4));
            apply_config((ph < 2) ? ALL_REGS : 5'($urandom_range(1, 31)), steps,
                         1'($urandom_range(0, 1)), limit, $urandom_range(0, 3) != 0,
                         5'($urandom_range(0, 31)));
            pick = $urandom_range(0, 2);
            gap_pct = (ph >= NUM_PHASES - 2) ? 0 : (pick == 0) ? 0 : (pick == 1) ? 10 : 30;
            n_words = $urandom_range(60, 100);
            repeat (n_words) send_word(rand_word());
        end

        in_valid <= 1'b0;
        gap_pct = 0;
        while (pending != 0) @(negedge clk);
        repeat (8) @(negedge clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
